[hw/rtl/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, codes and control types for the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int STRIDE_W        = 4;
    localparam int BASE_W          = 27;
    localparam int ADDR_W          = 48;
    localparam int STATUS_W        = 3;
    localparam int COND_W          = 2;
    localparam int CNT_W           = 10;
    localparam int PAGE_W          = 9;
    localparam int PAGE_SHIFT      = 12;
    localparam int CHUNK_SHIFT     = 21;
    localparam int PAGES_PER_CHUNK = 512;
    localparam int MAX_STRIDE      = 9;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 27;

    localparam int DEF_MAX_SLOTS   = 512;
    localparam int DEF_WORD_BITS   = 64;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 1'b1;

    typedef enum logic [COND_W-1:0] {
        MODE_EMPTY   = 2'd0,
        MODE_PARTIAL = 2'd1,
        MODE_FULL    = 2'd2
    } chunk_mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_RANGE     = 3'd2,
        STAT_MISALIGN  = 3'd3,
        STAT_NOT_ALLOC = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SPLIT,
        S_FREE,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic start_alloc;
        logic start_free;
        logic split_step;
        logic scan_eval;
        logic free_eval;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pre_err;
        logic split_done;
        logic scan_done;
    } dp_status_t;

endpackage

[hw/rtl/bsa_bitmap_mem.sv]
// ----------------------------------------------------------------------------
// bsa_bitmap_mem
// Bitmap word memory with registered read and per-word valid bits that
// clear the whole map at once.
// ----------------------------------------------------------------------------
module bsa_bitmap_mem #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 64,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    input  logic             clear,
    output logic [WIDTH-1:0] rdata,
    output logic             rvalid
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             rvalid_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (clear) begin
                valid_reg <= '0;
            end else if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= clear ? 1'b0 : valid_reg[raddr];
        end
    end

    assign rdata  = rdata_reg;
    assign rvalid = rvalid_reg;

endmodule

[hw/rtl/bsa_datapath.sv]
// ----------------------------------------------------------------------------
// bsa_datapath
// Configuration registers, address checks, bitmap word scan, slot count,
// chunk mode and the result register.
// ----------------------------------------------------------------------------
module bsa_datapath #(
    parameter int MAX_SLOTS = bsa_pkg::DEF_MAX_SLOTS,
    parameter int WORD_BITS = bsa_pkg::DEF_WORD_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [bsa_pkg::ADDR_W-1:0]        s_free_addr,
    input  bsa_pkg::ctrl_cmd_t                cmd,
    output bsa_pkg::dp_status_t               status,
    output logic [bsa_pkg::ADDR_W-1:0]        m_slot_addr,
    output logic [bsa_pkg::STATUS_W-1:0]      m_status,
    output logic [bsa_pkg::COND_W-1:0]        m_chunk_condition,
    output logic [bsa_pkg::CNT_W-1:0]         m_used_slots,
    output logic                              m_released
);

    import bsa_pkg::*;

    localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BP_W      = $clog2(WORD_BITS);
    localparam int SLOT_CAP  = (MAX_SLOTS < PAGES_PER_CHUNK) ? MAX_SLOTS : PAGES_PER_CHUNK;
    localparam int SB_W      = CNT_W + 1;
    localparam int SH_W      = SB_W + PAGE_W;

    logic [STRIDE_W-1:0]  stride_reg;
    logic [BASE_W-1:0]    base_reg;
    logic [WA_W-1:0]      word_reg, word_next;
    logic [SB_W-1:0]      word_base_reg, word_base_next;
    logic [PAGE_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    chunk_mode_t          mode_reg, mode_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    status_t              res_status_reg, res_status_next;
    logic                 res_rel_reg, res_rel_next;
    logic [ADDR_W-1:0]    m_slot_addr_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [COND_W-1:0]    m_cond_reg;
    logic [CNT_W-1:0]     m_used_reg;
    logic                 m_rel_reg;

    logic [STRIDE_W-1:0]  eff_stride;
    logic [CNT_W-1:0]     pages_per;
    logic [CNT_W-1:0]     slots;
    logic [PAGE_W-1:0]    page;
    logic [PAGE_W-1:0]    low_mask;
    logic [PAGE_W-1:0]    free_idx;
    logic                 base_hit;
    logic                 misalign;
    logic                 idx_oob;
    status_t              pre_status;

    logic [WORD_BITS-1:0] rd_data;
    logic                 rd_valid;
    logic [WORD_BITS-1:0] word_data;
    logic [WORD_BITS-1:0] avail;
    logic [WORD_BITS-1:0] free_vec;
    logic                 found;
    logic [BP_W-1:0]      found_bit;
    logic                 last_word;
    logic [SB_W-1:0]      slot_idx;
    logic [SH_W-1:0]      slot_shift;
    logic [ADDR_W-1:0]    alloc_addr;
    logic [CNT_W-1:0]     used_inc;
    logic [CNT_W-1:0]     used_dec;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 bit_set;
    logic                 split_done;
    logic                 mem_we;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_clear;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg <= '0;
            base_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_STRIDE: stride_reg <= cfg_wdata[STRIDE_W-1:0];
                CFG_BASE:   base_reg   <= cfg_wdata[BASE_W-1:0];
            endcase
        end
    end

    assign eff_stride = (stride_reg > STRIDE_W'(MAX_STRIDE)) ? STRIDE_W'(MAX_STRIDE) : stride_reg;
    assign pages_per  = CNT_W'(PAGES_PER_CHUNK) >> eff_stride;
    assign slots      = (pages_per > CNT_W'(SLOT_CAP)) ? CNT_W'(SLOT_CAP) : pages_per;

    // free address checks
    assign page     = s_free_addr[CHUNK_SHIFT-1:PAGE_SHIFT];
    assign low_mask = (PAGE_W'(1) << eff_stride) - PAGE_W'(1);
    assign free_idx = page >> eff_stride;
    assign base_hit = (s_free_addr[ADDR_W-1:CHUNK_SHIFT] == base_reg);
    assign misalign = (|s_free_addr[PAGE_SHIFT-1:0]) || (|(page & low_mask));
    assign idx_oob  = ({1'b0, free_idx} >= slots);

    always_comb begin
        if (mode_reg == MODE_EMPTY) begin
            pre_status = STAT_NOT_ALLOC;
        end else if (!base_hit) begin
            pre_status = STAT_RANGE;
        end else if (misalign) begin
            pre_status = STAT_MISALIGN;
        end else if (idx_oob) begin
            pre_status = STAT_RANGE;
        end else begin
            pre_status = STAT_OK;
        end
    end

    // word scan
    always_comb begin
        word_data = rd_valid ? rd_data : '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            avail[b] = (word_base_reg + SB_W'(b)) < SB_W'(slots);
        end
        free_vec  = ~word_data & avail;
        found     = |free_vec;
        found_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                found_bit = BP_W'(b);
            end
        end
    end

    assign last_word  = (word_base_reg + SB_W'(WORD_BITS)) >= SB_W'(slots);
    assign slot_idx   = word_base_reg + SB_W'(found_bit);
    assign slot_shift = SH_W'(slot_idx) << eff_stride;
    assign alloc_addr = {base_reg, slot_shift[PAGE_W-1:0], {PAGE_SHIFT{1'b0}}};
    assign used_inc   = used_reg + CNT_W'(1);
    assign used_dec   = (used_reg != '0) ? used_reg - CNT_W'(1) : '0;

    assign bit_mask   = WORD_BITS'(1) << rem_reg[BP_W-1:0];
    assign bit_set    = |(word_data & bit_mask);
    assign split_done = ({1'b0, rem_reg} < (PAGE_W + 1)'(WORD_BITS));

    assign mem_we    = (cmd.scan_eval && found) || (cmd.free_eval && bit_set);
    assign mem_wdata = cmd.scan_eval ? (word_data | (WORD_BITS'(1) << found_bit))
                                     : (word_data & ~bit_mask);
    assign mem_clear = (cmd.start_alloc && (mode_reg == MODE_EMPTY))
                    || (cmd.free_eval && bit_set && (mode_reg != MODE_FULL)
                        && (used_dec == '0));

    always_comb begin
        word_next       = word_reg;
        word_base_next  = word_base_reg;
        rem_next        = rem_reg;
        used_next       = used_reg;
        mode_next       = mode_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        res_rel_next    = res_rel_reg;

        if (cmd.start_alloc) begin
            word_next      = '0;
            word_base_next = '0;
            if (mode_reg == MODE_EMPTY) begin
                used_next = '0;
                mode_next = MODE_PARTIAL;
            end
        end

        if (cmd.start_free) begin
            word_next       = '0;
            rem_next        = free_idx;
            res_status_next = pre_status;
            res_addr_next   = '0;
            res_rel_next    = 1'b0;
        end

        if (cmd.split_step) begin
            rem_next  = rem_reg - PAGE_W'(WORD_BITS);
            word_next = word_reg + WA_W'(1);
        end

        if (cmd.scan_eval) begin
            if (found) begin
                res_addr_next   = alloc_addr;
                res_status_next = STAT_OK;
                res_rel_next    = 1'b0;
                used_next       = used_inc;
                if (used_inc >= slots) begin
                    mode_next = MODE_FULL;
                end
            end else if (last_word) begin
                res_addr_next   = '0;
                res_status_next = STAT_FULL;
                res_rel_next    = 1'b0;
                mode_next       = MODE_FULL;
            end else begin
                word_next      = word_reg + WA_W'(1);
                word_base_next = word_base_reg + SB_W'(WORD_BITS);
            end
        end

        if (cmd.free_eval) begin
            res_addr_next = '0;
            res_rel_next  = 1'b0;
            if (bit_set) begin
                res_status_next = STAT_OK;
                used_next       = used_dec;
                if (mode_reg == MODE_FULL) begin
                    mode_next = MODE_PARTIAL;
                end else if (used_dec == '0) begin
                    mode_next    = MODE_EMPTY;
                    res_rel_next = 1'b1;
                end
            end else begin
                res_status_next = STAT_NOT_ALLOC;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
            mode_reg <= MODE_EMPTY;
        end else begin
            used_reg <= used_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg       <= word_next;
        word_base_reg  <= word_base_next;
        rem_reg        <= rem_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        res_rel_reg    <= res_rel_next;
        if (cmd.load_out) begin
            m_slot_addr_reg <= res_addr_reg;
            m_status_reg    <= res_status_reg;
            m_cond_reg      <= mode_reg;
            m_used_reg      <= used_reg;
            m_rel_reg       <= res_rel_reg;
        end
    end

    bsa_bitmap_mem #(
        .DEPTH (NUM_WORDS),
        .WIDTH (WORD_BITS),
        .AW    (WA_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .waddr   (word_reg),
        .wdata   (mem_wdata),
        .raddr   (word_next),
        .clear   (mem_clear),
        .rdata   (rd_data),
        .rvalid  (rd_valid)
    );

    assign status.pre_err    = (pre_status != STAT_OK);
    assign status.split_done = split_done;
    assign status.scan_done  = found || last_word;

    assign m_slot_addr       = m_slot_addr_reg;
    assign m_status          = m_status_reg;
    assign m_chunk_condition = m_cond_reg;
    assign m_used_slots      = m_used_reg;
    assign m_released        = m_rel_reg;

endmodule

[hw/rtl/bsa_ctrl.sv]
// ----------------------------------------------------------------------------
// bsa_ctrl
// Request sequencer: alloc scan, free index split and check, result
// register hand-off.
// ----------------------------------------------------------------------------
module bsa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_req_type,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  bsa_pkg::dp_status_t  status,
    output bsa_pkg::ctrl_cmd_t   cmd
);

    import bsa_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        accept;
    logic        out_free;

    assign accept   = s_valid && (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_req_type == REQ_ALLOC) begin
                        state_next = S_SCAN;
                    end else if (status.pre_err) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_SPLIT;
                    end
                end
            end
            S_SCAN: begin
                if (status.scan_done) begin
                    state_next = S_OUT;
                end
            end
            S_SPLIT: begin
                if (status.split_done) begin
                    state_next = S_FREE;
                end
            end
            S_FREE: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.start_alloc = accept && (s_req_type == REQ_ALLOC);
        cmd.start_free  = accept && (s_req_type == REQ_FREE);
        cmd.split_step  = (state_reg == S_SPLIT) && !status.split_done;
        cmd.scan_eval   = (state_reg == S_SCAN);
        cmd.free_eval   = (state_reg == S_FREE);
        cmd.load_out    = (state_reg == S_OUT) && out_free;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[hw/rtl/bitmap_slot_allocator_unit.sv]
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_unit
// Slot allocator for one 2 MB chunk, tracked by a bitmap of slot words.
//
// Input channel s_*: one transaction per request, s_req_type selects alloc
// or free, s_free_addr is the byte address to free. Result channel m_*:
// one transaction per request with slot address, status, chunk condition,
// used count and release flag. The cfg_* port writes stride_log2 (index 0)
// and chunk_base (index 1); the user must write them only while the block
// is idle, which the block does not enforce. An alloc scans bitmap words in
// order, one word per cycle from the bitmap memory port, at most
// ceil(MAX_SLOTS / WORD_BITS) words, until a free slot or the last word. A
// free whose address fails the checks goes straight to the result; else
// the word index split steps to the word of the index, then that bit is
// checked and cleared. The result goes valid in the same cycle as the next
// request can be taken. Reset clears the map valid bits, the used count and
// the chunk mode at once; no clearing pass is needed. When the receiver
// stalls, the result holds in the output register and the next request is
// taken and worked; its result waits until the output register is free.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_unit #(
    parameter int MAX_SLOTS = bsa_pkg::DEF_MAX_SLOTS,
    parameter int WORD_BITS = bsa_pkg::DEF_WORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [bsa_pkg::ADDR_W-1:0]     s_free_addr,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [bsa_pkg::ADDR_W-1:0]     m_slot_addr,
    output logic [bsa_pkg::STATUS_W-1:0]   m_status,
    output logic [bsa_pkg::COND_W-1:0]     m_chunk_condition,
    output logic [bsa_pkg::CNT_W-1:0]      m_used_slots,
    output logic                           m_released
);

    import bsa_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    bsa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .status     (dp_status),
        .cmd        (cmd)
    );

    bsa_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_free_addr       (s_free_addr),
        .cmd               (cmd),
        .status            (dp_status),
        .m_slot_addr       (m_slot_addr),
        .m_status          (m_status),
        .m_chunk_condition (m_chunk_condition),
        .m_used_slots      (m_used_slots),
        .m_released        (m_released)
    );

endmodule
